/* design/tip_pkg.sv */
package tip_pkg;

  typedef struct packed {
    logic [1:0] base_mode;
    logic [7:0] max_width;
    logic [1:0] size_code;
  } cfg_t;

  localparam logic [1:0] REG_BASE_MODE = 2'd0;
  localparam logic [1:0] REG_MAX_WIDTH = 2'd1;
  localparam logic [1:0] REG_SIZE_CODE = 2'd2;

  localparam logic [1:0] MODE_AUTO = 2'd0;
  localparam logic [1:0] MODE_OCT  = 2'd1;
  localparam logic [1:0] MODE_DEC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  localparam logic [4:0] BASE_OCT = 5'd8;
  localparam logic [4:0] BASE_DEC = 5'd10;
  localparam logic [4:0] BASE_HEX = 5'd16;
  localparam logic [4:0] NOT_DIGIT = 5'd16;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
      end else if (c >= CH_LO_A && c <= CH_LO_F) begin
        d = c - CH_LO_A + 8'd10;
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
        d = c - CH_UP_A + 8'd10;
      end else begin
        d = 8'(NOT_DIGIT);
      end
      return d[4:0];
    end
  endfunction

endpackage

/* design/tip_if.sv */
interface tip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       at_end;

  modport source (output valid, output ch, output at_end, input ready);
  modport sink (input valid, input ch, input at_end, output ready);
endinterface

interface tip_out_if;
  logic        valid;
  logic        ready;
  logic        matched;
  logic [63:0] value;
  logic        char_kept;
  logic        sign_returned;

  modport source (output valid, output matched, output value, output char_kept,
                  output sign_returned, input ready);
  modport sink (input valid, input matched, input value, input char_kept,
                input sign_returned, output ready);
endinterface

/* design/tip_regs.sv */
module tip_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output tip_pkg::cfg_t       cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_mode <= tip_pkg::MODE_DEC;
      cfg.max_width <= 8'd0;
      cfg.size_code <= tip_pkg::SIZE_32;
    end else if (wr_en) begin
      unique case (reg_idx)
        tip_pkg::REG_BASE_MODE: cfg.base_mode <= pwdata[1:0];
        tip_pkg::REG_MAX_WIDTH: cfg.max_width <= pwdata[7:0];
        tip_pkg::REG_SIZE_CODE: cfg.size_code <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tip_pkg::REG_BASE_MODE: prdata = {30'd0, cfg.base_mode};
      tip_pkg::REG_MAX_WIDTH: prdata = {24'd0, cfg.max_width};
      tip_pkg::REG_SIZE_CODE: prdata = {30'd0, cfg.size_code};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

/* design/tip_core.sv */
module tip_core #(
  parameter int VALUE_BITS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  tip_pkg::cfg_t cfg,
  tip_in_if.sink        in_chan,
  tip_out_if.source     out_chan
);

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_ZERO   = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  logic                  item_valid;
  logic [7:0]            item_ch;
  logic                  item_end;
  logic                  advance;

  logic [1:0]            phase, phase_next;
  logic [VALUE_BITS-1:0] accum, accum_next;
  logic                  negative, negative_next;
  logic [4:0]            active_base, active_base_next;
  logic [7:0]            used_count, used_next;
  logic                  digit_seen, digit_seen_next;

  logic                  out_valid;
  logic                  matched;
  logic [63:0]           value;
  logic                  char_kept;
  logic                  sign_returned;

  logic                  emit;
  logic                  emit_ok;
  logic                  emit_kept;
  logic                  emit_sret;
  logic                  take_first;
  logic                  take_digit;
  logic [7:0]            used_inc;
  logic                  full_inc;
  logic [4:0]            digit;
  logic                  is_space;
  logic [VALUE_BITS-1:0] product;
  logic [VALUE_BITS-1:0] signed_val;
  logic [VALUE_BITS-1:0] size_mask;

  assign advance        = item_valid && (!out_valid || out_chan.ready);
  assign in_chan.ready  = !item_valid || advance;

  assign out_chan.valid         = out_valid;
  assign out_chan.matched       = matched;
  assign out_chan.value         = value;
  assign out_chan.char_kept     = char_kept;
  assign out_chan.sign_returned = sign_returned;

  assign used_inc = (used_count == 8'hff) ? 8'hff : used_count + 8'd1;
  assign full_inc = (cfg.max_width != 8'd0) && (used_inc >= cfg.max_width);
  assign digit    = tip_pkg::digit_of(item_ch);
  assign is_space = (item_ch == tip_pkg::CH_SPACE) ||
                    (item_ch >= tip_pkg::CH_TAB && item_ch <= tip_pkg::CH_CR);

  always_comb begin
    unique case (cfg.size_code)
      tip_pkg::SIZE_8:  size_mask = VALUE_BITS'(64'h0000_0000_0000_00ff);
      tip_pkg::SIZE_16: size_mask = VALUE_BITS'(64'h0000_0000_0000_ffff);
      tip_pkg::SIZE_32: size_mask = VALUE_BITS'(64'h0000_0000_ffff_ffff);
      default:          size_mask = VALUE_BITS'(64'hffff_ffff_ffff_ffff);
    endcase
  end

  always_comb begin
    phase_next       = phase;
    accum_next       = accum;
    negative_next    = negative;
    active_base_next = active_base;
    used_next        = used_count;
    digit_seen_next  = digit_seen;
    emit             = 1'b0;
    emit_ok          = 1'b0;
    emit_kept        = 1'b0;
    emit_sret        = 1'b0;
    take_first       = 1'b0;
    take_digit       = 1'b0;
    product          = '0;

    unique case (phase)
      PH_SKIP: begin
        if (item_end) begin
          emit = 1'b1;
        end else if (is_space) begin
        end else if (item_ch == tip_pkg::CH_MINUS || item_ch == tip_pkg::CH_PLUS) begin
          negative_next = (item_ch == tip_pkg::CH_MINUS);
          used_next     = used_inc;
          if (full_inc) begin
            emit      = 1'b1;
            emit_kept = 1'b1;
          end else begin
            phase_next = PH_SIGN;
          end
        end else begin
          take_first = 1'b1;
        end
      end
      PH_SIGN: begin
        if (item_end) begin
          emit      = 1'b1;
          emit_sret = 1'b1;
        end else begin
          take_first = 1'b1;
        end
      end
      PH_ZERO: begin
        if (item_end) begin
          emit    = 1'b1;
          emit_ok = 1'b1;
        end else if (item_ch == tip_pkg::CH_LO_X || item_ch == tip_pkg::CH_UP_X) begin
          active_base_next = tip_pkg::BASE_HEX;
          used_next        = used_inc;
          if (full_inc) begin
            emit    = 1'b1;
            emit_ok = 1'b1;
          end else begin
            phase_next = PH_DIGITS;
          end
        end else begin
          take_digit = 1'b1;
        end
      end
      default: begin
        if (item_end) begin
          emit    = 1'b1;
          emit_ok = digit_seen;
        end else begin
          take_digit = 1'b1;
        end
      end
    endcase

    if (take_first) begin
      if (cfg.base_mode == tip_pkg::MODE_AUTO && item_ch == tip_pkg::CH_ZERO) begin
        used_next        = used_inc;
        digit_seen_next  = 1'b1;
        accum_next       = '0;
        active_base_next = tip_pkg::BASE_OCT;
        if (full_inc) begin
          emit    = 1'b1;
          emit_ok = 1'b1;
        end else begin
          phase_next = PH_ZERO;
        end
      end else begin
        unique case (cfg.base_mode)
          tip_pkg::MODE_OCT: active_base_next = tip_pkg::BASE_OCT;
          tip_pkg::MODE_HEX: active_base_next = tip_pkg::BASE_HEX;
          default:           active_base_next = tip_pkg::BASE_DEC;
        endcase
        take_digit = 1'b1;
      end
    end

    if (take_digit) begin
      if (digit >= active_base_next) begin
        emit      = 1'b1;
        emit_ok   = digit_seen;
        emit_kept = 1'b1;
      end else begin
        priority case (active_base_next)
          tip_pkg::BASE_OCT: product = accum << 3;
          tip_pkg::BASE_HEX: product = accum << 4;
          default:           product = (accum << 3) + (accum << 1);
        endcase
        accum_next      = product + VALUE_BITS'(digit);
        digit_seen_next = 1'b1;
        used_next       = used_inc;
        phase_next      = PH_DIGITS;
        if (full_inc) begin
          emit    = 1'b1;
          emit_ok = 1'b1;
        end
      end
    end
  end

  assign signed_val = negative_next ? (VALUE_BITS'(0) - accum_next) : accum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_chan.ready) begin
      item_valid <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      item_ch  <= in_chan.ch;
      item_end <= in_chan.at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      accum       <= '0;
      negative    <= 1'b0;
      active_base <= 5'd0;
      used_count  <= 8'd0;
      digit_seen  <= 1'b0;
    end else if (advance) begin
      if (emit) begin
        phase       <= PH_SKIP;
        accum       <= '0;
        negative    <= 1'b0;
        active_base <= 5'd0;
        used_count  <= 8'd0;
        digit_seen  <= 1'b0;
      end else begin
        phase       <= phase_next;
        accum       <= accum_next;
        negative    <= negative_next;
        active_base <= active_base_next;
        used_count  <= used_next;
        digit_seen  <= digit_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      matched       <= emit_ok;
      value         <= emit_ok ? 64'(signed_val & size_mask) : 64'd0;
      char_kept     <= emit_kept;
      sign_returned <= emit_sret;
    end
  end

endmodule

/* design/text_integer_parser.sv */
// Parses signed integers from a character stream, one character or end-of-input
// mark per input transaction, and delivers one result transaction when a number
// ends (a non-digit, the end mark, or the configured width limit). A transaction
// is taken into an input register and resolved, once the result side is free,
// by a single shift-and-add digit step into the accumulator; one character
// is taken every cycle as long as results are taken. Base, width limit and result
// size are set through the APB registers at 0x0, 0x4 and 0x8; they must be
// written only while no number is in progress. No clearing pass follows reset.
module text_integer_parser #(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  tip_in_if.sink      in_chan,
  tip_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tip_pkg::cfg_t cfg;

  tip_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tip_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid && !out_chan.matched |-> out_chan.value == 64'd0)
    else $error("failed conversion carries a nonzero value");

  a_sign_ret: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid && out_chan.sign_returned |-> !out_chan.matched && !out_chan.char_kept)
    else $error("returned sign together with a match or kept character");

  a_byte_size: assert property (@(posedge clk) disable iff (rst)
    out_chan.valid && cfg.size_code == tip_pkg::SIZE_8 |-> out_chan.value[63:8] == 56'd0)
    else $error("one-byte result has upper bits set");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_chan.ready |-> out_chan.valid && !out_chan.ready)
    else $error("input stalled while the result side is free");

endmodule
